[src/fuzzy_match_scorer_top_assert.svh]
// ----------------------------------------------------------------------------
// fuzzy_match_scorer_top assertion macros
// Shared wrappers for the concurrent checks of the scorer
// ----------------------------------------------------------------------------
`ifndef FUZZY_MATCH_SCORER_TOP_ASSERT_SVH
`define FUZZY_MATCH_SCORER_TOP_ASSERT_SVH

// check a property at every rising edge, skipped while rst is high
`define FMS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every rising edge, reset included
`define FMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/fms_pkg.sv]
// ----------------------------------------------------------------------------
// fms_pkg
// Types, constants and helpers shared by the fuzzy match scorer
// ----------------------------------------------------------------------------
package fms_pkg;

   // string geometry
   localparam int MAX_LENGTH = 4096;
   localparam int POS_W      = 13;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LENGTH - 1);

   // accumulator saturates at +-2^40, so 42 bits hold it
   localparam int ACC_W   = 42;
   localparam int DELTA_W = 22;
   localparam logic signed [ACC_W:0] ACC_MAX = 43'sd1 <<< 40;
   localparam logic signed [ACC_W:0] ACC_MIN = -(43'sd1 <<< 40);
   localparam logic signed [ACC_W-1:0] OUT_MAX = 42'sd2147483647;
   localparam logic signed [ACC_W-1:0] OUT_MIN = -42'sd2147483648;

   localparam logic signed [ACC_W-1:0]   BASE_SCORE        = 42'sd100;
   localparam logic signed [DELTA_W-1:0] START_MATCH_BONUS = 22'sd15;

   // byte codes
   localparam logic [7:0] CH_SLASH      = 8'h2f;
   localparam logic [7:0] CH_BACKSLASH  = 8'h5c;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7a;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5a;

   // register map
   localparam int CSR_ADDR_W = 4;
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LEADING_WEIGHT   = 4'd0,
      CSR_LEADING_LIMIT    = 4'd1,
      CSR_UNMATCHED_WEIGHT = 4'd2,
      CSR_ADJACENT_BONUS   = 4'd3,
      CSR_GAP_WEIGHT       = 4'd4,
      CSR_CASE_BONUS       = 4'd5,
      CSR_PATH_SEP_BONUS   = 4'd6,
      CSR_WORD_SEP_BONUS   = 4'd7
   } csr_addr_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_match;
      logic       is_last;
   } fms_req_type;

   typedef struct packed {
      logic signed [31:0] score;
      logic               no_match;
   } fms_rsp_type;

   typedef struct packed {
      logic signed [6:0] leading_weight;
      logic signed [7:0] leading_limit;
      logic signed [6:0] unmatched_weight;
      logic signed [7:0] adjacent_bonus;
      logic signed [6:0] gap_weight;
      logic signed [7:0] case_bonus;
      logic signed [7:0] path_sep_bonus;
      logic signed [7:0] word_sep_bonus;
   } fms_cfg_type;

   typedef struct packed {
      logic [POS_W-1:0]        position;
      logic [7:0]              previous_byte;
      logic [POS_W-1:0]        last_match_position;
      logic                    seen_match;
      logic signed [ACC_W-1:0] running_score;
   } fms_state_type;

   // add with clamp to the accumulator range
   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0]   acc,
      input logic signed [DELTA_W-1:0] delta
   );
      logic signed [ACC_W:0] sum;
      sum = {acc[ACC_W-1], acc} + {{(ACC_W + 1 - DELTA_W){delta[DELTA_W-1]}}, delta};
      if (sum > ACC_MAX) begin
         sum = ACC_MAX;
      end else if (sum < ACC_MIN) begin
         sum = ACC_MIN;
      end
      return sum[ACC_W-1:0];
   endfunction

endpackage

[src/fms_step.sv]
// ----------------------------------------------------------------------------
// fms_step
// Scoring logic for one byte: next string state and the final result
// ----------------------------------------------------------------------------
module fms_step
   import fms_pkg::*;
(
   input  fms_cfg_type   cfg,
   input  fms_state_type cur,
   input  fms_req_type   item,
   output fms_state_type nxt,
   output fms_rsp_type   result
);

   logic signed [20:0]        lead_prod;
   logic signed [20:0]        lead_term;
   logic signed [20:0]        lim_ext;
   logic signed [POS_W:0]     gap_dist;
   logic signed [20:0]        gap_prod;
   logic [POS_W:0]            lmp_next;
   logic                      is_seq;
   logic signed [DELTA_W-1:0] d_main;
   logic signed [DELTA_W-1:0] d_case;
   logic signed [DELTA_W-1:0] d_sep;
   logic                      prev_lower;
   logic                      cur_upper;
   logic                      prev_path;
   logic                      prev_word;
   logic                      at_start;
   logic signed [ACC_W-1:0]   acc1;
   logic signed [ACC_W-1:0]   acc2;
   logic signed [ACC_W-1:0]   acc3;
   logic                      seen_after;

   // leading penalty, clamped from below
   assign lead_prod = 21'(cfg.leading_weight) * 21'($signed({1'b0, cur.position}));
   assign lim_ext   = 21'(cfg.leading_limit);
   assign lead_term = (lead_prod < lim_ext) ? lim_ext : lead_prod;

   // distance to the previous match
   assign gap_dist = $signed({1'b0, cur.position}) - $signed({1'b0, cur.last_match_position});
   assign gap_prod = 21'(cfg.gap_weight) * 21'(gap_dist);
   assign lmp_next = {1'b0, cur.last_match_position} + (POS_W + 1)'(1);
   assign is_seq   = ({1'b0, cur.position} == lmp_next);

   // byte classes
   assign at_start   = (cur.position == '0);
   assign prev_lower = (cur.previous_byte >= CH_LOWER_A) && (cur.previous_byte <= CH_LOWER_Z);
   assign cur_upper  = (item.char_code >= CH_UPPER_A) && (item.char_code <= CH_UPPER_Z);
   assign prev_path  = (cur.previous_byte == CH_SLASH) || (cur.previous_byte == CH_BACKSLASH);
   assign prev_word  = (cur.previous_byte == CH_SPACE) || (cur.previous_byte == CH_UNDERSCORE);

   // the three score terms, applied in order
   always_comb begin
      d_main = DELTA_W'(cfg.unmatched_weight);
      d_case = '0;
      d_sep  = '0;
      if (item.is_match) begin
         if (!cur.seen_match) begin
            d_main = DELTA_W'(lead_term);
         end else if (is_seq) begin
            d_main = DELTA_W'(cfg.adjacent_bonus);
         end else begin
            d_main = DELTA_W'(gap_prod);
         end
         if (at_start) begin
            d_case = START_MATCH_BONUS;
         end else begin
            if (prev_lower && cur_upper) begin
               d_case = DELTA_W'(cfg.case_bonus);
            end
            if (prev_path) begin
               d_sep = DELTA_W'(cfg.path_sep_bonus);
            end else if (prev_word) begin
               d_sep = DELTA_W'(cfg.word_sep_bonus);
            end
         end
      end
   end

   // each term saturates on its own
   assign acc1 = sat_add(cur.running_score, d_main);
   assign acc2 = sat_add(acc1, d_case);
   assign acc3 = sat_add(acc2, d_sep);

   assign seen_after = cur.seen_match | item.is_match;

   // next state, back to the start of a string after the last byte
   always_comb begin
      if (item.is_last) begin
         nxt.position            = '0;
         nxt.previous_byte       = '0;
         nxt.last_match_position = '0;
         nxt.seen_match          = 1'b0;
         nxt.running_score       = BASE_SCORE;
      end else begin
         nxt.position            = (cur.position < POS_LAST) ?
                                   cur.position + POS_W'(1) : cur.position;
         nxt.previous_byte       = item.char_code;
         nxt.last_match_position = item.is_match ? cur.position : cur.last_match_position;
         nxt.seen_match          = seen_after;
         nxt.running_score       = acc3;
      end
   end

   // final score clamped to 32 bits
   always_comb begin
      if (acc3 > OUT_MAX) begin
         result.score = OUT_MAX[31:0];
      end else if (acc3 < OUT_MIN) begin
         result.score = OUT_MIN[31:0];
      end else begin
         result.score = acc3[31:0];
      end
      result.no_match = ~seen_after;
   end

endmodule

[src/fuzzy_match_scorer_top.sv]
// ----------------------------------------------------------------------------
// fuzzy_match_scorer_top
// Fuzzy match scorer: one candidate byte per transfer, one score per string
// ----------------------------------------------------------------------------
//  channel  direction  ports                       carries
//  req      in         req_valid/req_stall/req_data one byte with match and last flags
//  rsp      out        rsp_valid/rsp_stall/rsp_data score and no-match flag
//  csr      in         csr_we/csr_addr/csr_wdata    weight and bonus registers
//
// One byte per cycle while req_stall is low; the string state updates in the cycle of the transfer.
// The result of a last byte is registered into the result queue and shown once the results ahead of it have left.
// A two-entry result queue keeps input flowing while a result is stalled;
// req_stall rises only when both entries are occupied.
// Synchronous reset restores the register defaults and empties the queue.
// ----------------------------------------------------------------------------
module fuzzy_match_scorer_top
   import fms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fms_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fms_rsp_type           rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [7:0]            csr_wdata
);

   fms_cfg_type   cfg_ff;
   fms_cfg_type   cfg_in;
   fms_state_type state_ff;
   fms_state_type state_in;
   fms_rsp_type   step_rsp;
   fms_rsp_type   queue_ff [2];
   logic          wr_ptr_ff;
   logic          rd_ptr_ff;
   logic [1:0]    count_ff;
   logic [1:0]    count_in;
   logic          req_xfer;
   logic          rsp_xfer;
   logic          push;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_LEADING_WEIGHT:   cfg_in.leading_weight   = csr_wdata[6:0];
            CSR_LEADING_LIMIT:    cfg_in.leading_limit    = csr_wdata;
            CSR_UNMATCHED_WEIGHT: cfg_in.unmatched_weight = csr_wdata[6:0];
            CSR_ADJACENT_BONUS:   cfg_in.adjacent_bonus   = csr_wdata;
            CSR_GAP_WEIGHT:       cfg_in.gap_weight       = csr_wdata[6:0];
            CSR_CASE_BONUS:       cfg_in.case_bonus       = csr_wdata;
            CSR_PATH_SEP_BONUS:   cfg_in.path_sep_bonus   = csr_wdata;
            CSR_WORD_SEP_BONUS:   cfg_in.word_sep_bonus   = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leading_weight   <= -7'sd5;
         cfg_ff.leading_limit    <= -8'sd15;
         cfg_ff.unmatched_weight <= -7'sd1;
         cfg_ff.adjacent_bonus   <= 8'sd40;
         cfg_ff.gap_weight       <= -7'sd3;
         cfg_ff.case_bonus       <= 8'sd30;
         cfg_ff.path_sep_bonus   <= 8'sd30;
         cfg_ff.word_sep_bonus   <= 8'sd25;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshakes
   assign req_stall = (count_ff == 2'd2);
   assign req_xfer  = req_valid & ~req_stall;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_xfer  = rsp_valid & ~rsp_stall;
   assign push      = req_xfer & req_data.is_last;

   // per-byte scoring
   fms_step u_step (
      .cfg    (cfg_ff),
      .cur    (state_ff),
      .item   (req_data),
      .nxt    (state_in),
      .result (step_rsp)
   );

   // string state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.position            <= '0;
         state_ff.previous_byte       <= '0;
         state_ff.last_match_position <= '0;
         state_ff.seen_match          <= 1'b0;
         state_ff.running_score       <= BASE_SCORE;
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   // result queue occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !rsp_xfer) begin
         count_in = count_ff + 2'd1;
      end else if (!push && rsp_xfer) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (rsp_xfer) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // result queue payload
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= step_rsp;
      end
   end

   assign rsp_data = queue_ff[rd_ptr_ff];

endmodule

[src/fms_checker.sv]
// ----------------------------------------------------------------------------
// fms_checker
// Port-level checks for the fuzzy match scorer, bound to the top level
// ----------------------------------------------------------------------------
`include "fuzzy_match_scorer_top_assert.svh"

module fms_checker
   import fms_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input fms_req_type           req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input fms_rsp_type           rsp_data
);

   // a stalled result holds
   `FMS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // reset empties the result queue
   `FMS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result shown right after reset")

   // a new result only follows a transfer of a last byte
   `FMS_ASSERT(a_rsp_after_last, clock, reset, $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_data.is_last), "result without a last byte")

   // input stalls only while results are waiting
   `FMS_ASSERT(a_stall_needs_rsp, clock, reset, req_stall |-> rsp_valid, "input stalled with no result pending")

endmodule

bind fuzzy_match_scorer_top fms_checker u_fms_checker (.*);

[test/fuzzy_match_scorer_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fuzzy_match_scorer_checker
// Watches the byte and score channels of the fuzzy match scorer, keeps its own
// copy of the string state and weight registers, predicts the score of every
// completed string and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module fuzzy_match_scorer_checker
   import fms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  fms_req_type           req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  fms_rsp_type           rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [7:0]            csr_wdata,
   output int                    fail_count,
   output int                    scores_pending
);

   localparam longint ACC_LIMIT = 64'sd1 <<< 40;
   localparam longint SCORE_MAX = 64'sd2147483647;
   localparam longint SCORE_MIN = -64'sd2147483648;

   // shadow of the weight registers and of the per-string state
   fms_cfg_type      weights;
   logic [POS_W-1:0] str_pos;
   logic [POS_W-1:0] last_hit_pos;
   logic [7:0]       prev_char;
   logic             seen_hit;
   longint           run_score;

   fms_rsp_type expected_scores[$];
   int          mismatches = 0;

   function automatic void clear_string_state();
      str_pos      = '0;
      last_hit_pos = '0;
      prev_char    = '0;
      seen_hit     = 1'b0;
      run_score    = longint'(BASE_SCORE);
   endfunction

   function automatic longint clamp_acc(input longint v);
      if (v > ACC_LIMIT) begin
         return ACC_LIMIT;
      end
      if (v < -ACC_LIMIT) begin
         return -ACC_LIMIT;
      end
      return v;
   endfunction

   // advance the string state by one byte; returns 1 when a score is due
   function automatic bit score_byte(input fms_req_type b, output fms_rsp_type res);
      longint acc;
      longint lead;
      int     p;
      int     lhp;
      acc = run_score;
      p   = int'(str_pos);
      lhp = int'(last_hit_pos);
      res = '0;
      if (b.is_match) begin
         // leading penalty on the first hit, then adjacent or gap term
         if (!seen_hit) begin
            lead = longint'(weights.leading_weight) * p;
            if (lead < weights.leading_limit) begin
               lead = weights.leading_limit;
            end
            acc = clamp_acc(acc + lead);
         end else if (p == lhp + 1) begin
            acc = clamp_acc(acc + longint'(weights.adjacent_bonus));
         end else begin
            acc = clamp_acc(acc + longint'(weights.gap_weight) * (p - lhp));
         end
         // bonuses from the byte before the hit, or the start bonus at position 0
         if (p > 0) begin
            if (prev_char >= CH_LOWER_A && prev_char <= CH_LOWER_Z &&
                b.char_code >= CH_UPPER_A && b.char_code <= CH_UPPER_Z) begin
               acc = clamp_acc(acc + longint'(weights.case_bonus));
            end
            if (prev_char == CH_SLASH || prev_char == CH_BACKSLASH) begin
               acc = clamp_acc(acc + longint'(weights.path_sep_bonus));
            end else if (prev_char == CH_SPACE || prev_char == CH_UNDERSCORE) begin
               acc = clamp_acc(acc + longint'(weights.word_sep_bonus));
            end
         end else begin
            acc = clamp_acc(acc + longint'(START_MATCH_BONUS));
         end
         seen_hit     = 1'b1;
         last_hit_pos = str_pos;
      end else begin
         acc = clamp_acc(acc + longint'(weights.unmatched_weight));
      end
      prev_char = b.char_code;
      if (str_pos < POS_LAST) begin
         str_pos = str_pos + POS_W'(1);
      end
      run_score = acc;
      if (!b.is_last) begin
         return 1'b0;
      end
      // final score saturates to 32 bits
      if (acc > SCORE_MAX) begin
         acc = SCORE_MAX;
      end else if (acc < SCORE_MIN) begin
         acc = SCORE_MIN;
      end
      res.score    = acc[31:0];
      res.no_match = !seen_hit;
      clear_string_state();
      return 1'b1;
   endfunction

   // sample both channels and the register port at every edge
   always @(posedge clock) begin
      fms_rsp_type want;
      bit          bad;
      if (reset) begin
         clear_string_state();
         weights.leading_weight   = -7'sd5;
         weights.leading_limit    = -8'sd15;
         weights.unmatched_weight = -7'sd1;
         weights.adjacent_bonus   = 8'sd40;
         weights.gap_weight       = -7'sd3;
         weights.case_bonus       = 8'sd30;
         weights.path_sep_bonus   = 8'sd30;
         weights.word_sep_bonus   = 8'sd25;
         expected_scores.delete();
      end else begin
         // score transfer against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_scores.size() == 0) begin
               $display("%0t ns: score %0d no_match %0b with no string pending",
                        $time, rsp_data.score, rsp_data.no_match);
               mismatches++;
            end else begin
               want = expected_scores.pop_front();
               bad  = 1'b0;
               if (rsp_data.score !== want.score) begin
                  $display("%0t ns: score expected %0d, got %0d",
                           $time, want.score, rsp_data.score);
                  bad = 1'b1;
               end
               if (rsp_data.no_match !== want.no_match) begin
                  $display("%0t ns: no_match expected %0b, got %0b",
                           $time, want.no_match, rsp_data.no_match);
                  bad = 1'b1;
               end
               mismatches += bad;
            end
         end
         // byte transfer
         if (req_valid && !req_stall) begin
            if (score_byte(req_data, want)) begin
               expected_scores.push_back(want);
            end
         end
         // register write, indexes past the map are dropped
         if (csr_we) begin
            case (csr_addr)
               CSR_LEADING_WEIGHT:   weights.leading_weight   = csr_wdata[6:0];
               CSR_LEADING_LIMIT:    weights.leading_limit    = csr_wdata;
               CSR_UNMATCHED_WEIGHT: weights.unmatched_weight = csr_wdata[6:0];
               CSR_ADJACENT_BONUS:   weights.adjacent_bonus   = csr_wdata;
               CSR_GAP_WEIGHT:       weights.gap_weight       = csr_wdata[6:0];
               CSR_CASE_BONUS:       weights.case_bonus       = csr_wdata;
               CSR_PATH_SEP_BONUS:   weights.path_sep_bonus   = csr_wdata;
               CSR_WORD_SEP_BONUS:   weights.word_sep_bonus   = csr_wdata;
               default: ;
            endcase
         end
      end
      fail_count     <= mismatches;
      scores_pending <= expected_scores.size();
   end

endmodule

[test/tb_fuzzy_match_scorer_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fuzzy_match_scorer_top
// Drives candidate strings into the fuzzy match scorer: a few hand-made
// strings for each bonus and penalty, then random strings of mixed length and
// match density under maximum, minimum and random weights with
// changing idle and stall patterns. Scores are checked by the checker module
// beside the block.
// ----------------------------------------------------------------------------
module tb_fuzzy_match_scorer_top;
   import fms_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int SEGMENT_ITEMS  = 425;
   localparam logic [CSR_ADDR_W-1:0] FIRST_UNUSED_CSR = CSR_WORD_SEP_BONUS + 1'b1;
   // registers 0, 2 and 4 are 7 bits wide
   localparam bit NARROW_CSR [8] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

   typedef enum int {WEIGHTS_MAX, WEIGHTS_MIN, WEIGHTS_RANDOM} weight_set_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   fms_req_type           req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   fms_rsp_type           rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [7:0]            csr_wdata = '0;

   int fail_count;
   int scores_pending;
   int send_idle_pct = 36;
   int rsp_stall_pct = 82;
   int items_sent    = 0;
   int quiet_cycles  = 0;

   fuzzy_match_scorer_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   fuzzy_match_scorer_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .scores_pending (scores_pending)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // random back-pressure on the score channel
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("FAIL fuzzy_match_scorer_top");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one byte transfer, with random idle cycles ahead of it
   task automatic push_byte(input logic [7:0] ch, input logic hit, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data.char_code <= ch;
      req_data.is_match  <= hit;
      req_data.is_last   <= fin;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // bit i of hits marks byte i as matched
   task automatic send_word(input string text, input logic [31:0] hits);
      int i;
      for (i = 0; i < text.len(); i++) begin
         push_byte(text[i], hits[i], i == text.len() - 1);
      end
   endtask

   task automatic send_random_string();
      int         len;
      int         hit_pct;
      int         i;
      logic [7:0] ch;
      case ($urandom_range(19))
         0:       len = $urandom_range(64, 25);
         1, 2, 3: len = $urandom_range(24, 9);
         default: len = $urandom_range(8, 1);
      endcase
      case ($urandom_range(4))
         0:       hit_pct = 0;
         1:       hit_pct = 25;
         2:       hit_pct = 60;
         3:       hit_pct = 85;
         default: hit_pct = 100;
      endcase
      for (i = 0; i < len; i++) begin
         // lean toward letters and separators so the bonuses fire often
         case ($urandom_range(9))
            0, 1, 2: ch = CH_LOWER_A + 8'($urandom_range(25));
            3, 4:    ch = CH_UPPER_A + 8'($urandom_range(25));
            5:       ch = $urandom_range(1) ? CH_SLASH : CH_BACKSLASH;
            6:       ch = $urandom_range(1) ? CH_SPACE : CH_UNDERSCORE;
            default: ch = 8'($urandom_range(255));
         endcase
         push_byte(ch, $urandom_range(99) < hit_pct, i == len - 1);
      end
   endtask

   // let every pending score come out, then a short pause
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (scores_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all weight registers, then one index past the map
   task automatic program_weights(input weight_set_type set);
      int i;
      for (i = 0; i < 8; i++) begin
         csr_we   <= 1'b1;
         csr_addr <= CSR_ADDR_W'(i);
         case (set)
            WEIGHTS_MAX: csr_wdata <= NARROW_CSR[i] ? 8'h3f : 8'h7f;
            WEIGHTS_MIN: csr_wdata <= NARROW_CSR[i] ? 8'h40 : 8'h80;
            default:     csr_wdata <= 8'($urandom_range(255));
         endcase
         @(posedge clock);
      end
      csr_addr  <= FIRST_UNUSED_CSR + CSR_ADDR_W'($urandom_range(7));
      csr_wdata <= 8'($urandom_range(255));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int seg;
      int target;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // hand-made strings under reset weights
      send_word("A", 32'b1);
      send_word("ab", 32'b0);
      send_word("xY", 32'b10);
      send_word("/a", 32'b10);
      send_word("\\b", 32'b10);
      send_word(" c", 32'b10);
      send_word("_d", 32'b10);
      send_word("abc", 32'b111);
      send_word("a..b", 32'b1001);
      push_byte(8'h00, 1'b1, 1'b0);
      push_byte(8'hff, 1'b0, 1'b1);

      // random segments with different weights and idle patterns
      for (seg = 0; seg < 4; seg++) begin
         settle();
         case (seg)
            0: begin
               send_idle_pct = 36;
               rsp_stall_pct <= 82;
               program_weights(WEIGHTS_MAX);
            end
            1: begin
               send_idle_pct = 82;
               rsp_stall_pct <= 36;
               program_weights(WEIGHTS_MIN);
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct <= 0;
               program_weights(WEIGHTS_RANDOM);
            end
         endcase
         target = items_sent + SEGMENT_ITEMS;
         while (items_sent < target) begin
            send_random_string();
         end
      end
      settle();

      if (fail_count == 0) begin
         $display("PASS fuzzy_match_scorer_top");
      end else begin
         $display("FAIL fuzzy_match_scorer_top");
      end
      $finish;
   end

endmodule
